>>> rtl/srdep_pkg.sv
// ----------------------------------------------------------------------------
// srdep_pkg
// Shared types, constants and controller commands for the sparse row projector.
// ----------------------------------------------------------------------------
package srdep_pkg;

  localparam int unsigned VoxelCountDefault = 65536;
  localparam int unsigned AccWidth = 40;
  localparam int unsigned RowWidth = 24;
  localparam int unsigned QWidth = 32;  // Q2.30 working word
  localparam int unsigned ExpSteps = 12;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TERM  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] voxel_index;
    logic [15:0] voxel_value;
    logic [15:0] weight;
    logic        end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [16:0] transmission;
    logic [23:0] row_number;
    logic        sum_saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,     // image read in flight
    ST_MUL,      // product registered
    ST_ACC,      // accumulate, maybe close
    ST_EXP_INIT,
    ST_HORNER_M, // y*p
    ST_HORNER_D, // (y*p)/k, p update
    ST_SQ_M,
    ST_SQ_R,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic write_voxel;
    logic read_voxel;
    logic mul;
    logic acc;
    logic exp_init;
    logic horner_mul;
    logic horner_div;
    logic sq_mul;
    logic sq_round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic close_pending;
    logic k_last;
    logic sq_last;
  } status_t;

  // reciprocal of k (1 to 12) in Q1.32, rounded up
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] r;
    begin
      case (k)
        4'd1:    r = 33'h1_0000_0000;
        4'd2:    r = 33'h0_8000_0000;
        4'd3:    r = 33'h0_5555_5556;
        4'd4:    r = 33'h0_4000_0000;
        4'd5:    r = 33'h0_3333_3334;
        4'd6:    r = 33'h0_2AAA_AAAB;
        4'd7:    r = 33'h0_2492_4925;
        4'd8:    r = 33'h0_2000_0000;
        4'd9:    r = 33'h0_1C71_C71D;
        4'd10:   r = 33'h0_1999_999A;
        4'd11:   r = 33'h0_1745_D175;
        4'd12:   r = 33'h0_1555_5556;
        default: r = 33'h1_0000_0000;
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/srdep_ctrl.sv
// ----------------------------------------------------------------------------
// srdep_ctrl
// Sequencer: steps one request through gather, accumulate and exp evaluation.
// ----------------------------------------------------------------------------
module srdep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  output logic                in_ready,
  input  logic                out_pending,
  input  srdep_pkg::status_t  status,
  output srdep_pkg::cmd_t     cmd
);

  srdep_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srdep_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      srdep_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_action)
            srdep_pkg::ACT_WRITE: cmd.write_voxel = 1'b1;
            srdep_pkg::ACT_TERM: begin
              cmd.read_voxel = 1'b1;
              state_next = srdep_pkg::ST_READ;
            end
            srdep_pkg::ACT_CLOSE: begin
              cmd.exp_init = 1'b1;
              state_next = srdep_pkg::ST_HORNER_M;
            end
            default: ;
          endcase
        end
      end
      srdep_pkg::ST_READ: begin
        cmd.mul = 1'b1;
        state_next = srdep_pkg::ST_MUL;
      end
      srdep_pkg::ST_MUL: begin
        cmd.acc = 1'b1;
        state_next = srdep_pkg::ST_ACC;
      end
      srdep_pkg::ST_ACC: begin
        if (status.close_pending) begin
          cmd.exp_init = 1'b1;
          state_next = srdep_pkg::ST_HORNER_M;
        end else begin
          state_next = srdep_pkg::ST_IDLE;
        end
      end
      srdep_pkg::ST_EXP_INIT: state_next = srdep_pkg::ST_HORNER_M;
      srdep_pkg::ST_HORNER_M: begin
        cmd.horner_mul = 1'b1;
        state_next = srdep_pkg::ST_HORNER_D;
      end
      srdep_pkg::ST_HORNER_D: begin
        cmd.horner_div = 1'b1;
        state_next = status.k_last ? srdep_pkg::ST_SQ_M : srdep_pkg::ST_HORNER_M;
      end
      srdep_pkg::ST_SQ_M: begin
        cmd.sq_mul = 1'b1;
        state_next = srdep_pkg::ST_SQ_R;
      end
      srdep_pkg::ST_SQ_R: begin
        cmd.sq_round = 1'b1;
        state_next = status.sq_last ? srdep_pkg::ST_OUT : srdep_pkg::ST_SQ_M;
      end
      srdep_pkg::ST_OUT: begin
        if (!out_pending) begin
          cmd.out_load = 1'b1;
          state_next = srdep_pkg::ST_IDLE;
        end
      end
      default: state_next = srdep_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/srdep_datapath.sv
// ----------------------------------------------------------------------------
// srdep_datapath
// Image memory, multiply-accumulate, exp unit and output register.
// ----------------------------------------------------------------------------
module srdep_datapath #(
  parameter int unsigned VOXEL_COUNT = srdep_pkg::VoxelCountDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srdep_pkg::in_item_t  in_data,
  input  srdep_pkg::cmd_t      cmd,
  output srdep_pkg::status_t   status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srdep_pkg::out_item_t out_data
);

  // a 16-bit voxel index reaches at most 65536 entries
  localparam int unsigned MemDepth = (VOXEL_COUNT > 65536) ? 65536 : VOXEL_COUNT;
  localparam int unsigned AddrWidth = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam logic [39:0] AccMax = {srdep_pkg::AccWidth{1'b1}};
  localparam logic [39:0] ExpLimit = 40'd12 << 24;
  localparam logic [31:0] QOne = 32'h4000_0000;

  logic [15:0] image_mem [MemDepth];
  logic [15:0] vox_rd;
  logic        idx_ok;
  logic        rd_ok;
  logic [15:0] wt;
  logic        close_pending;
  logic [31:0] prod;
  logic [39:0] acc;
  logic        sat;
  logic [23:0] row_cnt;
  logic [31:0] y;
  logic [31:0] p;
  logic        zero_out;
  logic [3:0]  k;
  logic [1:0]  sq_cnt;
  logic [63:0] mprod;
  logic [40:0] sum_wide;
  logic [31:0] yp;
  logic [64:0] qprod;
  logic [31:0] quo;
  logic [16:0] tx;

  assign idx_ok = ({16'd0, in_data.voxel_index} < 32'(VOXEL_COUNT));

  always_ff @(posedge clk) begin
    if (cmd.write_voxel && idx_ok) begin
      image_mem[in_data.voxel_index[AddrWidth-1:0]] <= in_data.voxel_value;
    end
    if (cmd.read_voxel) begin
      vox_rd <= image_mem[in_data.voxel_index[AddrWidth-1:0]];
    end
  end

  assign sum_wide = {1'b0, acc} + {9'd0, prod};
  assign yp = 32'(mprod >> 30);
  assign qprod = {33'd0, yp} * {32'd0, srdep_pkg::recip(k)};
  assign quo = 32'(qprod >> 32);
  assign tx = 17'((p + 32'h2000) >> 14);

  always_ff @(posedge clk) begin
    if (cmd.read_voxel) begin
      rd_ok <= idx_ok;
      wt <= in_data.weight;
      close_pending <= in_data.end_of_row;
    end
    if (cmd.mul) begin
      prod <= rd_ok ? (32'(vox_rd) * 32'(wt)) : 32'd0;
    end
    if (cmd.exp_init) begin
      y <= 32'(acc << 2);
      p <= QOne;
      zero_out <= (acc >= ExpLimit);
      k <= 4'(srdep_pkg::ExpSteps);
      sq_cnt <= '0;
    end
    if (cmd.horner_mul) begin
      mprod <= {32'd0, y} * {32'd0, p};
    end
    if (cmd.horner_div) begin
      p <= QOne - quo;
      k <= k - 4'd1;
    end
    if (cmd.sq_mul) begin
      mprod <= {32'd0, p} * {32'd0, p};
    end
    if (cmd.sq_round) begin
      p <= 32'((mprod + 64'h2000_0000) >> 30);
      sq_cnt <= sq_cnt + 2'd1;
    end
    if (cmd.out_load) begin
      out_data.transmission <= zero_out ? 17'd0 : tx;
      out_data.row_number <= row_cnt;
      out_data.sum_saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sat <= 1'b0;
      row_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (sum_wide >= {1'b0, AccMax}) begin
          acc <= AccMax;
          sat <= 1'b1;
        end else begin
          acc <= sum_wide[39:0];
        end
      end
      if (cmd.out_load) begin
        acc <= '0;
        sat <= 1'b0;
        row_cnt <= row_cnt + 24'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.close_pending = close_pending;
  assign status.k_last = (k == 4'd1);
  assign status.sq_last = (sq_cnt == 2'd3);

endmodule

>>> rtl/sparse_row_dot_exp_projector.sv
// ----------------------------------------------------------------------------
// sparse_row_dot_exp_projector
// Forward projector: sparse row dot product with exp(-sum) transmission out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry requests: voxel writes, matrix terms (with an
//   end-of-row mark) and empty-row closes. out_valid/out_ready carry one
//   transmission result per closed row, with its row number and a flag set
//   when the row accumulator clamped at its maximum.
// Steps:
//   A voxel write or no-op is handled in the idle state. A matrix term
//   steps through memory read, 16x16 multiply and saturating 40-bit add.
//   A row close adds the exp unit: 12 Horner steps (multiply, then
//   reciprocal multiply) and 4 squarings, then the result load. The
//   exp unit's 32x32 multiplier is shared by Horner steps and squarings.
// Reset:
//   rst clears the accumulator, row counter, saturation flag and output
//   valid. The image memory is not cleared; gather only written voxels.
// Stall:
//   The output register holds its result while out_ready is low; a term
//   that follows may still be taken, but the next close waits in its last
//   state until the register is free.
// ----------------------------------------------------------------------------
module sparse_row_dot_exp_projector #(
  parameter int unsigned VOXEL_COUNT = srdep_pkg::VoxelCountDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srdep_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srdep_pkg::out_item_t out_data
);

  srdep_pkg::cmd_t    cmd;
  srdep_pkg::status_t status;
  logic               out_pending;

  // result register still holds an untaken item
  assign out_pending = out_valid && !out_ready;

  srdep_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_action   (in_data.action),
    .in_ready    (in_ready),
    .out_pending (out_pending),
    .status      (status),
    .cmd         (cmd)
  );

  srdep_datapath #(
    .VOXEL_COUNT (VOXEL_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse row projector. It loads voxels and
// streams matrix rows through the request channel, predicts every row's
// transmission, row number and saturation flag, and compares each result
// with the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam longint unsigned AccMax = (64'd1 << 40) - 1;
  localparam int unsigned CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  srdep_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srdep_pkg::out_item_t out_data;

  sparse_row_dot_exp_projector uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // predictor state: mirror of the image and the row accumulator
  logic [15:0] image_mirror [int];
  int written_list[$];
  longint unsigned row_sum;
  logic [23:0] next_row;
  logic sat_flag;
  srdep_pkg::out_item_t expected_rows[$];

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int ready_pct = 100;

  // round(65536*exp(-s)): Horner series on s/16, then square four times
  function automatic logic [16:0] transmission_of(longint unsigned s);
    longint unsigned y;
    longint unsigned p;
    int k;
    if (s >= (64'd12 << 24)) return '0;
    y = s << 2;
    p = 64'd1 << 30;
    for (k = 12; k >= 1; k--) p = (64'd1 << 30) - (((y * p) >> 30) / 64'(k));
    for (k = 0; k < 4; k++) p = (p * p + (64'd1 << 29)) >> 30;
    return 17'((p + (64'd1 << 13)) >> 14);
  endfunction

  function automatic void close_row();
    srdep_pkg::out_item_t r;
    r.transmission = transmission_of(row_sum);
    r.row_number = next_row;
    r.sum_saturated = sat_flag;
    expected_rows.push_back(r);
    next_row = next_row + 1'b1;
    row_sum = 0;
    sat_flag = 1'b0;
  endfunction

  function automatic void predict_request(srdep_pkg::in_item_t it);
    longint unsigned vox;
    case (srdep_pkg::action_t'(it.action))
      srdep_pkg::ACT_WRITE: begin
        if (!image_mirror.exists(int'(it.voxel_index)))
          written_list.push_back(int'(it.voxel_index));
        image_mirror[int'(it.voxel_index)] = it.voxel_value;
      end
      srdep_pkg::ACT_TERM: begin
        vox = image_mirror.exists(int'(it.voxel_index)) ?
              longint'(image_mirror[int'(it.voxel_index)]) : 0;
        row_sum = row_sum + vox * longint'(it.weight);
        if (row_sum >= AccMax) begin
          row_sum = AccMax;
          sat_flag = 1'b1;
        end
        if (it.end_of_row) close_row();
      end
      srdep_pkg::ACT_CLOSE: close_row();
      default: ;
    endcase
  endfunction

  // accepted requests feed the predictor; all sampling is at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_request(in_data);
  end

  // result checker
  always @(posedge clk) begin
    srdep_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = expected_rows.pop_front();
        if (out_data.transmission !== want.transmission ||
            out_data.row_number !== want.row_number ||
            out_data.sum_saturated !== want.sum_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: expected trans %0d sat %0b, got row %0d trans %0d sat %0b",
                     want.row_number, want.transmission, want.sum_saturated,
                     out_data.row_number, out_data.transmission, out_data.sum_saturated);
        end
      end
    end
  end

  // receiver stalls: the ready density is redrawn periodically from 100, 70, 30 or 5 percent
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        2: ready_pct <= 30;
        default: ready_pct <= 5;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request, sent in bursts with random gaps between them
  task automatic send_request(srdep_pkg::action_t act, logic [15:0] idx, logic [15:0] val,
                              logic [15:0] wt, logic eor);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{action: act, voxel_index: idx, voxel_value: val, weight: wt,
                 end_of_row: eor};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_written();
    return 16'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // extremes of the fields, every action, unused fields, close with pending terms
  task automatic test_directed();
    send_request(srdep_pkg::ACT_CLOSE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);  // empty row gives 1.0
    send_request(srdep_pkg::ACT_WRITE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_request(srdep_pkg::ACT_WRITE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_request(srdep_pkg::ACT_WRITE, 16'h0002, 16'h1000, 16'hAAAA, 1'b1);
    send_request(srdep_pkg::ACT_WRITE, 16'h5555, 16'h0001, 16'h5555, 1'b0);
    send_request(srdep_pkg::ACT_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);    // no result
    send_request(srdep_pkg::ACT_TERM, 16'h0002, 16'hFFFF, 16'h1000, 1'b1);   // sum 1.0
    send_request(srdep_pkg::ACT_TERM, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);   // zero voxel
    send_request(srdep_pkg::ACT_TERM, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);   // largest product
    send_request(srdep_pkg::ACT_TERM, 16'h0002, 16'h0000, 16'hC000, 1'b1);   // exactly 12.0
    send_request(srdep_pkg::ACT_TERM, 16'h0002, 16'h0000, 16'hBFFF, 1'b1);   // just under 12.0
    send_request(srdep_pkg::ACT_TERM, 16'h5555, 16'h0000, 16'h0000, 1'b1);   // zero weight
    send_request(srdep_pkg::ACT_TERM, 16'h5555, 16'h0000, 16'h0001, 1'b0);   // smallest product
    send_request(srdep_pkg::ACT_TERM, 16'h0002, 16'h0000, 16'h0800, 1'b0);
    send_request(srdep_pkg::ACT_CLOSE, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // close, pending terms
    send_request(srdep_pkg::ACT_NOP, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_request(srdep_pkg::ACT_TERM, 16'h0002, 16'h0000, 16'h0400, 1'b1);
  endtask

  // a row of largest products long enough to clamp the accumulator
  task automatic test_saturation();
    for (int i = 0; i < 262; i++)
      send_request(srdep_pkg::ACT_TERM, 16'hFFFF, 16'($urandom), 16'hFFFF, i == 261);
  endtask

  // random rows over a growing image, with some noise
  task automatic test_random_rows(int n);
    int sent;
    int len;
    logic [15:0] wt;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_request(srdep_pkg::ACT_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom));
          sent++;
        end
        2: begin
          send_request(srdep_pkg::ACT_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom));
          sent++;
        end
        default: begin
          len = $urandom_range(0, 8);
          for (int i = 0; i < len; i++) begin
            wt = 16'($urandom);
            if ($urandom_range(0, 1)) wt = wt >> $urandom_range(4, 10);
            send_request(srdep_pkg::ACT_TERM, pick_written(), 16'($urandom), wt,
                         (i == len - 1) && ($urandom_range(0, 4) != 0));
          end
          if (len == 0 || !in_data.end_of_row)
            send_request(srdep_pkg::ACT_CLOSE, 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
          sent += len + 1;
        end
      endcase
      if (sent > n / 2 && sent < n / 2 + 10) drain_results();
    end
  endtask

  initial begin
    row_sum = 0;
    next_row = '0;
    sat_flag = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain_results();
    test_saturation();
    test_random_rows(1570);
    drain_results();
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/srdep_pkg.sv
rtl/srdep_ctrl.sv
rtl/srdep_datapath.sv
rtl/sparse_row_dot_exp_projector.sv
test/tb.sv
